// File: rtl/core/pli_pkg.sv
// Shared constants and types for the positional list block.
`default_nettype none
package pli_pkg;
    localparam int CAPACITY = 64;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 7;
    localparam int OP_W     = 3;
    localparam int ST_W     = 2;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int LEN_W    = 7;

    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic               ins;
        logic               del;
        logic [CMP_W-1:0]   pos;
        logic [VAL_W-1:0]   val;
    } t_cmd;
endpackage
`default_nettype wire

// File: rtl/core/pli_cell.sv
// One list entry: loads the new value, its left or its right neighbor.
`default_nettype none
module pli_cell (
    input  wire                         i_clk,
    input  wire [pli_pkg::IDX_W-1:0]    i_idx,
    input  wire pli_pkg::t_cmd          i_cmd,
    input  wire [pli_pkg::CNT_W-1:0]    i_count,
    input  wire [pli_pkg::VAL_W-1:0]    i_left,
    input  wire [pli_pkg::VAL_W-1:0]    i_right,
    output logic [pli_pkg::VAL_W-1:0]   o_val,
    output logic [pli_pkg::VAL_W-1:0]   o_tail_val
);
    import pli_pkg::*;

    logic [VAL_W-1:0] r_val;
    logic [VAL_W-1:0] n_val;
    logic [CMP_W-1:0] w_idx;
    logic [CMP_W-1:0] w_idx1;
    logic [CMP_W-1:0] w_cnt;

    assign w_idx  = CMP_W'(i_idx);
    assign w_idx1 = w_idx + CMP_W'(1);
    assign w_cnt  = CMP_W'(i_count);

    always_comb begin
        n_val = r_val;
        if (i_cmd.ins) begin
            if (w_idx == i_cmd.pos) begin
                n_val = i_cmd.val;
            end else if (w_idx > i_cmd.pos && w_idx <= w_cnt) begin
                n_val = i_left;
            end
        end else if (i_cmd.del) begin
            if (w_idx >= i_cmd.pos && w_idx1 < w_cnt) begin
                n_val = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val      = r_val;
    // masked so the top level can OR all cells into the tail value
    assign o_tail_val = (w_idx1 == w_cnt) ? r_val : '0;
endmodule
`default_nettype wire

// File: rtl/core/positional_list_insert_delete_top.sv
// Top level of the positional list: control, cell chain and result register.
//
// Ordered list of up to CAPACITY signed 32-bit values, one value per cell.
// Slave channel (s): one transaction per operation; tdata carries opcode,
// item_value and position. Master channel (m): one transaction per accepted
// operation, with status, new length, first and last value (0 when empty).
// The result is registered: the accepting edge shifts the cell chain and
// updates the count; the tail value is then gathered through an AND-OR over
// all cells and loaded into the output register once it is free. A new
// operation is not accepted until the previous result has been loaded.
// Insert at p moves every cell above p one place up in parallel; delete
// moves them one place down. Errors leave the list unchanged.
// While the output register holds an untaken result, the next operation
// may still be accepted and applied; its result waits until the register
// frees, and o_s_tready stays low meanwhile.
// Reset (synchronous, active low) empties the list and drops both valids;
// cell contents are not cleared, only entries below the count are read.
`default_nettype none
module positional_list_insert_delete_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire [47:0]  i_s_tdata,   // opcode[2:0], item_value[34:3], position[41:35]
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [79:0] o_m_tdata    // status[1:0], list_length[8:2],
                                     // first_value[40:9], last_value[72:41]
);
    import pli_pkg::*;

    logic [OP_W-1:0]  w_op;
    logic [VAL_W-1:0] w_in_val;
    logic [POS_W-1:0] w_in_pos;
    logic             w_acc;
    logic             w_load;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_pend;
    logic [ST_W-1:0]  r_st;
    logic [ST_W-1:0]  n_st;
    logic             r_ovalid;
    logic [79:0]      r_out;

    t_cmd             w_cmd;
    logic [CMP_W-1:0] w_cnt;
    logic [CMP_W-1:0] w_p;

    logic [VAL_W-1:0] w_val  [CAPACITY];
    logic [VAL_W-1:0] w_tail [CAPACITY];
    logic [VAL_W-1:0] w_last;

    assign w_op     = i_s_tdata[2:0];
    assign w_in_val = i_s_tdata[34:3];
    assign w_in_pos = i_s_tdata[41:35];

    assign o_s_tready = !r_pend;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_load     = r_pend && (!r_ovalid || i_m_tready);
    assign w_cnt      = CMP_W'(r_count);

    always_comb begin
        w_cmd     = '0;
        w_cmd.val = w_in_val;
        w_p       = CMP_W'(w_in_pos);
        n_st      = ST_OK;
        n_count   = r_count;
        case (w_op)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
                if (w_op == OP_INS_FRONT) begin
                    w_p = '0;
                end else if (w_op == OP_INS_BACK) begin
                    w_p = w_cnt;
                end
                if (w_p > w_cnt) begin
                    n_st = ST_RANGE;
                end else if (w_cnt >= CMP_W'(CAPACITY)) begin
                    n_st = ST_FULL;
                end else begin
                    w_cmd.ins = w_acc;
                    n_count   = r_count + CNT_W'(1);
                end
            end
            OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
                if (w_op == OP_DEL_FRONT) begin
                    w_p = '0;
                end else if (w_op == OP_DEL_BACK) begin
                    w_p = w_cnt - CMP_W'(1);
                end
                if (r_count == '0) begin
                    n_st = ST_EMPTY;
                end else if (w_p >= w_cnt) begin
                    n_st = ST_RANGE;
                end else begin
                    w_cmd.del = w_acc;
                    n_count   = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_st = ST_OK;
            end
        endcase
        w_cmd.pos = w_p;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VAL_W-1:0] w_l;
        logic [VAL_W-1:0] w_r;
        if (g == 0) begin : g_first
            assign w_l = '0;
        end else begin : g_mid_l
            assign w_l = w_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_r = '0;
        end else begin : g_mid_r
            assign w_r = w_val[g+1];
        end
        pli_cell u_cell (
            .i_clk      (i_clk),
            .i_idx      (IDX_W'(g)),
            .i_cmd      (w_cmd),
            .i_count    (r_count),
            .i_left     (w_l),
            .i_right    (w_r),
            .o_val      (w_val[g]),
            .o_tail_val (w_tail[g])
        );
    end

    always_comb begin
        w_last = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_last = w_last | w_tail[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count <= n_count;
                r_pend  <= 1'b1;
            end else if (w_load) begin
                r_pend  <= 1'b0;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_st <= n_st;
        end
        if (w_load) begin
            r_out <= {7'd0,
                      (r_count == '0) ? {VAL_W{1'b0}} : w_last,
                      (r_count == '0) ? {VAL_W{1'b0}} : w_val[0],
                      LEN_W'(r_count),
                      r_st};
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("list count above capacity");
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc |=> $stable(r_count))
        else $error("count changed without an input transaction");
    a_pend_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_pend && !o_s_tready)
        else $error("accepted operation not pending");
    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_m_tvalid && !r_pend)
        else $error("result load lost");
`endif
endmodule
`default_nettype wire
